// ----- sv/ssot_pkg.sv -----
// Shared types and constants for the sphere shape overlap test.
package ssot_pkg;

  localparam int COORD_BITS   = 24;
  localparam int INDEX_BITS   = 16;
  localparam int AXIS_BITS    = 16;
  localparam int CFG_IDX_BITS = 2;

  // Internal widths, derived from the coordinate width apart from the fixed SPLIT point.
  localparam int DW    = COORD_BITS + 1;       // centre difference
  localparam int DPW   = COORD_BITS + 17;      // difference times axis component
  localparam int PSW   = COORD_BITS + 19;      // projection sum and clamp compare
  localparam int PCW   = COORD_BITS + 15;      // clamped projection
  localparam int QW    = COORD_BITS + 31;      // clamped projection times axis
  localparam int CLW   = COORD_BITS + 34;      // closest point offset, Q.28
  localparam int SPLIT = 32;
  localparam int HIW   = CLW - SPLIT;
  localparam int SQW   = 2 * CLW;
  localparam int SUMW  = SQW + 2;
  localparam int SSQW  = 2 * COORD_BITS + 2;   // sphere path square
  localparam int SSUMW = SSQW + 2;

  typedef enum logic [1:0] {
    CMD_SPHERE = 2'd0,
    CMD_AABB   = 2'd1,
    CMD_OBB    = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_CENTER_Z = 2'd2,
    REG_RADIUS   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]                   command;
    logic [INDEX_BITS-1:0]        item_index;
    logic signed [COORD_BITS-1:0] vec_a_x;
    logic signed [COORD_BITS-1:0] vec_a_y;
    logic signed [COORD_BITS-1:0] vec_a_z;
    logic signed [COORD_BITS-1:0] vec_b_x;
    logic signed [COORD_BITS-1:0] vec_b_y;
    logic signed [COORD_BITS-1:0] vec_b_z;
    logic [3*AXIS_BITS-1:0]       obb_axis_0;
    logic [3*AXIS_BITS-1:0]       obb_axis_1;
    logic [3*AXIS_BITS-1:0]       obb_axis_2;
    logic                         last_item;
  } in_req_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] out_index;
    logic                  hit;
    logic                  out_last;
  } out_res_t;

  typedef struct packed {
    logic [1:0]            cmd;
    logic [INDEX_BITS-1:0] index;
    logic                  last;
    logic                  aabb_hit;
    logic                  sph_hit;
  } tag_t;

endpackage

// ----- sv/sphere_shape_overlap_test_top.sv -----
// Top level of the sphere shape overlap test: eight-stage overlap pipeline.
//
//  channel | ports                          | handshake
//  --------+--------------------------------+-------------------------------------
//  input   | start, busy, in_req            | taken when start is high, busy low
//  result  | out_valid, out_res             | one-cycle strobe, cannot be held off
//  config  | cfg_we, cfg_index, cfg_wdata   | written on an edge with cfg_we high, out of reset
//
// One request enters per clock; the pipeline depth is set by the
// OBB path (projection multiply, clamp, rebuild multiply, split 58-bit squaring,
// final sum and compare). busy is always low, since the pipeline never stalls.
// Reset clears the query registers and all stage valid bits.
module sphere_shape_overlap_test_top (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  output logic                                    busy,
  input  ssot_pkg::in_req_t                       in_req,
  output logic                                    out_valid,
  output ssot_pkg::out_res_t                      out_res,
  input  logic                                    cfg_we,
  input  logic [ssot_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [ssot_pkg::COORD_BITS-1:0]         cfg_wdata
);
  import ssot_pkg::*;

  localparam int C = COORD_BITS;

  // Query registers.
  logic signed [C-1:0] qcx_r, qcy_r, qcz_r;
  logic [C-2:0]        qr_r;
  logic [2*C-3:0]      qr_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qcx_r <= '0;
      qcy_r <= '0;
      qcz_r <= '0;
      qr_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_X: qcx_r <= cfg_wdata;
        REG_CENTER_Y: qcy_r <= cfg_wdata;
        REG_CENTER_Z: qcz_r <= cfg_wdata;
        REG_RADIUS:   qr_r  <= cfg_wdata[C-2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    qr_sq_r <= qr_r * qr_r;
  end

  logic signed [C-1:0] qc [3];
  assign qc[0] = qcx_r;
  assign qc[1] = qcy_r;
  assign qc[2] = qcz_r;

  assign busy = 1'b0;

  // Stage valid bits and tags.
  logic v_r [7];
  tag_t t_r [7];
  logic accept;
  assign accept = start && !busy;

  // ---------------- Stage 1: differences, AABB test, sphere radius sum.
  logic signed [C-1:0]         a_in [3];
  logic signed [C-1:0]         b_in [3];
  logic signed [AXIS_BITS-1:0] ax_in [3][3];
  logic signed [DW-1:0]        d_nxt [3];
  logic                        aabb_nxt;
  logic [C-1:0]                rs_nxt;
  logic [C-2:0]                rc;
  logic signed [C+1:0]         qcw, qrw, aw, bw;

  assign a_in[0] = in_req.vec_a_x;
  assign a_in[1] = in_req.vec_a_y;
  assign a_in[2] = in_req.vec_a_z;
  assign b_in[0] = in_req.vec_b_x;
  assign b_in[1] = in_req.vec_b_y;
  assign b_in[2] = in_req.vec_b_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ax_in[0][k] = in_req.obb_axis_0[AXIS_BITS*k +: AXIS_BITS];
      ax_in[1][k] = in_req.obb_axis_1[AXIS_BITS*k +: AXIS_BITS];
      ax_in[2][k] = in_req.obb_axis_2[AXIS_BITS*k +: AXIS_BITS];
    end
  end

  always_comb begin
    aabb_nxt = 1'b1;
    qrw = $signed({3'b000, qr_r});
    qcw = '0;
    aw  = '0;
    bw  = '0;
    for (int k = 0; k < 3; k++) begin
      d_nxt[k] = $signed({qc[k][C-1], qc[k]}) - $signed({a_in[k][C-1], a_in[k]});
      qcw = $signed({{2{qc[k][C-1]}}, qc[k]});
      aw  = $signed({{2{a_in[k][C-1]}}, a_in[k]});
      bw  = $signed({{2{b_in[k][C-1]}}, b_in[k]});
      if ((qcw + qrw) < aw || (qcw - qrw) > bw) begin
        aabb_nxt = 1'b0;
      end
    end
    // A negative candidate radius counts as zero.
    rc     = b_in[0][C-1] ? '0 : b_in[0][C-2:0];
    rs_nxt = {1'b0, qr_r} + {1'b0, rc};
  end

  logic signed [DW-1:0]        s1_d_r [3];
  logic signed [C-1:0]         s1_b_r [3];
  logic signed [AXIS_BITS-1:0] s1_ax_r [3][3];
  logic [C-1:0]                s1_rs_r;

  always_ff @(posedge clk) begin
    s1_d_r  <= d_nxt;
    s1_b_r  <= b_in;
    s1_ax_r <= ax_in;
    s1_rs_r <= rs_nxt;
    t_r[0]  <= '{cmd: in_req.command, index: in_req.item_index,
                 last: in_req.last_item, aabb_hit: aabb_nxt, sph_hit: 1'b0};
  end

  // ---------------- Stage 2: projection products, sphere squares.
  logic signed [DPW-1:0]       s2_dp_r [3][3];
  logic signed [SSQW-1:0]      s2_sq_r [3];
  logic [2*C-1:0]              s2_rsq_r;
  logic signed [C-1:0]         s2_b_r [3];
  logic signed [DW-1:0]        s2_d_r [3];
  logic signed [AXIS_BITS-1:0] s2_ax_r [3][3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        s2_dp_r[i][k] <= s1_d_r[k] * s1_ax_r[i][k];
      end
      s2_sq_r[i] <= s1_d_r[i] * s1_d_r[i];
    end
    s2_rsq_r <= s1_rs_r * s1_rs_r;
    s2_b_r   <= s1_b_r;
    s2_d_r   <= s1_d_r;
    s2_ax_r  <= s1_ax_r;
    t_r[1]   <= t_r[0];
  end

  // ---------------- Stage 3: projection sum and clamp, sphere compare.
  logic signed [PSW-1:0] p_sum [3];
  logic signed [PSW-1:0] h_val [3];
  logic signed [PSW-1:0] negh  [3];
  logic signed [PSW-1:0] p_cl  [3];
  logic [SSUMW-1:0]      ssum;
  logic                  sph_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p_sum[i] = PSW'(s2_dp_r[i][0]) + PSW'(s2_dp_r[i][1]) + PSW'(s2_dp_r[i][2]);
      h_val[i] = PSW'(s2_b_r[i]) <<< 14;
      negh[i]  = -h_val[i];
      // The lower bound goes first, so a negative half size ends up at h.
      p_cl[i]  = p_sum[i];
      if (p_cl[i] < negh[i]) begin
        p_cl[i] = negh[i];
      end
      if (p_cl[i] > h_val[i]) begin
        p_cl[i] = h_val[i];
      end
    end
    ssum = SSUMW'(unsigned'(s2_sq_r[0])) + SSUMW'(unsigned'(s2_sq_r[1]))
         + SSUMW'(unsigned'(s2_sq_r[2]));
    sph_nxt = ssum <= SSUMW'(s2_rsq_r);
  end

  logic signed [PCW-1:0]       s3_pc_r [3];
  logic signed [DW-1:0]        s3_d_r [3];
  logic signed [AXIS_BITS-1:0] s3_ax_r [3][3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s3_pc_r[i] <= p_cl[i][PCW-1:0];
    end
    s3_d_r  <= s2_d_r;
    s3_ax_r <= s2_ax_r;
    t_r[2]  <= '{cmd: t_r[1].cmd, index: t_r[1].index, last: t_r[1].last,
                 aabb_hit: t_r[1].aabb_hit, sph_hit: sph_nxt};
  end

  // ---------------- Stage 4: rebuild products.
  logic signed [QW-1:0] s4_q_r [3][3];
  logic signed [DW-1:0] s4_d_r [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        s4_q_r[i][k] <= s3_pc_r[i] * s3_ax_r[i][k];
      end
    end
    s4_d_r <= s3_d_r;
    t_r[3] <= t_r[2];
  end

  // ---------------- Stage 5: closest point offset from the query centre, magnitude.
  logic signed [CLW-1:0] cl [3];
  logic [CLW-1:0]        s5_mag_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cl[k] = CLW'(s4_q_r[0][k]) + CLW'(s4_q_r[1][k]) + CLW'(s4_q_r[2][k])
            - (CLW'(s4_d_r[k]) <<< 28);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      s5_mag_r[k] <= cl[k][CLW-1] ? CLW'(-cl[k]) : CLW'(cl[k]);
    end
    t_r[4] <= t_r[3];
  end

  // ---------------- Stage 6: partial products of the squares.
  logic [2*SPLIT-1:0]   s6_ll_r [3];
  logic [SPLIT+HIW-1:0] s6_lh_r [3];
  logic [2*HIW-1:0]     s6_hh_r [3];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      s6_ll_r[k] <= s5_mag_r[k][SPLIT-1:0] * s5_mag_r[k][SPLIT-1:0];
      s6_lh_r[k] <= s5_mag_r[k][SPLIT-1:0] * s5_mag_r[k][CLW-1:SPLIT];
      s6_hh_r[k] <= s5_mag_r[k][CLW-1:SPLIT] * s5_mag_r[k][CLW-1:SPLIT];
    end
    t_r[5] <= t_r[4];
  end

  // ---------------- Stage 7: assemble each square.
  logic [SQW-1:0] s7_sq_r [3];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      s7_sq_r[k] <= SQW'(s6_ll_r[k]) + (SQW'(s6_lh_r[k]) << (SPLIT + 1))
                  + (SQW'(s6_hh_r[k]) << (2 * SPLIT));
    end
    t_r[6] <= t_r[5];
  end

  // ---------------- Stage 8: distance compare and result select.
  logic [SUMW-1:0] obb_sum;
  logic            obb_hit;
  logic            hit_nxt;

  always_comb begin
    obb_sum = SUMW'(s7_sq_r[0]) + SUMW'(s7_sq_r[1]) + SUMW'(s7_sq_r[2]);
    obb_hit = obb_sum <= (SUMW'(qr_sq_r) << 56);
    case (t_r[6].cmd)
      CMD_SPHERE: hit_nxt = t_r[6].sph_hit;
      CMD_AABB:   hit_nxt = t_r[6].aabb_hit;
      CMD_OBB:    hit_nxt = obb_hit;
      default:    hit_nxt = 1'b0;
    endcase
  end

  logic     out_valid_r;
  out_res_t out_res_r;

  always_ff @(posedge clk) begin
    out_res_r <= '{out_index: t_r[6].index, hit: hit_nxt, out_last: t_r[6].last};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < 7; s++) begin
        v_r[s] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else begin
      v_r[0] <= accept;
      for (int s = 1; s < 7; s++) begin
        v_r[s] <= v_r[s-1];
      end
      out_valid_r <= v_r[6];
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// ----- verif/overlap_checker.sv -----
// Checker: predicts each overlap result from the request and the query registers.
module overlap_checker
  import ssot_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    busy,
  input  in_req_t                 in_req,
  input  logic                    out_valid,
  input  out_res_t                out_res,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]   cfg_wdata,
  output int                      fails,
  output int                      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  longint  query_c[3];
  longint  query_r;
  out_res_t expected_results[$];

  function automatic logic overlap_of(in_req_t r);
    longint a[3], b[3], ax[3][3], d[3], cl[3], p, h, rc;
    logic signed [127:0] c0, c1, c2, dist_sq, lim;
    logic hit;
    a[0] = r.vec_a_x; a[1] = r.vec_a_y; a[2] = r.vec_a_z;
    b[0] = r.vec_b_x; b[1] = r.vec_b_y; b[2] = r.vec_b_z;
    for (int k = 0; k < 3; k++) begin
      ax[0][k] = $signed(r.obb_axis_0[16*k +: 16]);
      ax[1][k] = $signed(r.obb_axis_1[16*k +: 16]);
      ax[2][k] = $signed(r.obb_axis_2[16*k +: 16]);
    end
    hit = 1'b0;
    case (r.command)
      CMD_SPHERE: begin
        rc = (b[0] < 0) ? 0 : b[0];
        c0 = a[0] - query_c[0]; c1 = a[1] - query_c[1]; c2 = a[2] - query_c[2];
        dist_sq = c0 * c0 + c1 * c1 + c2 * c2;
        lim = query_r + rc;
        hit = (dist_sq <= lim * lim);
      end
      CMD_AABB: begin
        hit = 1'b1;
        for (int i = 0; i < 3; i++)
          if (query_c[i] + query_r < a[i] || query_c[i] - query_r > b[i]) hit = 1'b0;
      end
      CMD_OBB: begin
        for (int k = 0; k < 3; k++) begin
          d[k] = query_c[k] - a[k];
          cl[k] = a[k] <<< 28;
        end
        for (int i = 0; i < 3; i++) begin
          p = d[0] * ax[i][0] + d[1] * ax[i][1] + d[2] * ax[i][2];
          h = b[i] * 16384;
          // A negative half size clamps every projection to that half size.
          if (p < -h) p = -h;
          if (p > h) p = h;
          for (int k = 0; k < 3; k++) cl[k] += p * ax[i][k];
        end
        c0 = cl[0] - (query_c[0] <<< 28);
        c1 = cl[1] - (query_c[1] <<< 28);
        c2 = cl[2] - (query_c[2] <<< 28);
        dist_sq = c0 * c0 + c1 * c1 + c2 * c2;
        lim = query_r <<< 28;
        hit = (dist_sq <= lim * lim);
      end
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    out_res_t exp_res;
    if (!rst_n) begin
      query_c[0] = 0; query_c[1] = 0; query_c[2] = 0; query_r = 0;
      expected_results.delete();
      fails = 0;
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $error("result index %0d arrived with no request outstanding",
                 out_res.out_index);
          fails++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_res.out_index !== exp_res.out_index) begin
            $error("out_index: expected %0d, got %0d", exp_res.out_index, out_res.out_index);
            fails++;
          end
          if (out_res.hit !== exp_res.hit) begin
            $error("hit: expected %0d, got %0d", exp_res.hit, out_res.hit);
            fails++;
          end
          if (out_res.out_last !== exp_res.out_last) begin
            $error("out_last: expected %0d, got %0d", exp_res.out_last, out_res.out_last);
            fails++;
          end
        end
      end
      if (start && !busy) begin
        exp_res.out_index = in_req.item_index;
        exp_res.hit       = overlap_of(in_req);
        exp_res.out_last  = in_req.last_item;
        expected_results.push_back(exp_res);
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_CENTER_X: query_c[0] = $signed(cfg_wdata);
          REG_CENTER_Y: query_c[1] = $signed(cfg_wdata);
          REG_CENTER_Z: query_c[2] = $signed(cfg_wdata);
          REG_RADIUS:   query_r = cfg_wdata[COORD_BITS-2:0];
          default: ;
        endcase
      end
    end
  end
endmodule

// ----- verif/testbench.sv -----
// Top of the overlap test bench: clock, reset, request stimulus and verdict.
module testbench;
  import ssot_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_CYCLES = 200000;
  localparam logic [15:0] ONE = 16'h4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_req_t in_req = '0;
  logic out_valid;
  out_res_t out_res;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [COORD_BITS-1:0] cfg_wdata = '0;
  int fails, pending, cycles = 0;
  bit gaps_on = 1'b1;
  logic signed [COORD_BITS-1:0] qc[3];
  logic [COORD_BITS-1:0] qr;
  logic [15:0] next_index = '0;

  always #5 clk = ~clk;

  sphere_shape_overlap_test_top dut (
    .clk, .rst_n, .start, .busy, .in_req, .out_valid, .out_res,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  overlap_checker checker_i (
    .clk, .rst_n, .start, .busy, .in_req, .out_valid, .out_res,
    .cfg_we, .cfg_index, .cfg_wdata, .fails, .pending
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [COORD_BITS-1:0] val);
    cfg_we = 1'b1; cfg_index = idx; cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_query(logic signed [COORD_BITS-1:0] x, logic signed [COORD_BITS-1:0] y,
                           logic signed [COORD_BITS-1:0] z, logic [COORD_BITS-2:0] r);
    qc[0] = x; qc[1] = y; qc[2] = z; qr = {1'b0, r};
    write_reg(REG_CENTER_X, x);
    write_reg(REG_CENTER_Y, y);
    write_reg(REG_CENTER_Z, z);
    write_reg(REG_RADIUS, {1'($urandom_range(0, 1)), r});
  endtask

  // Called at a falling edge; leaves start low at a falling edge.
  task automatic send(in_req_t r);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_req = r; start = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic drain;
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  function automatic logic signed [COORD_BITS-1:0] near(int axis, int spread);
    return COORD_BITS'(qc[axis] + $signed(COORD_BITS'($urandom_range(0, 2 * spread)))
                       - spread);
  endfunction

  function automatic logic [47:0] unit_axis(int k, bit neg);
    logic [47:0] v;
    v = '0;
    v[16*k +: 16] = neg ? -ONE : ONE;
    return v;
  endfunction

  function automatic in_req_t random_request();
    in_req_t r;
    int spread, perm;
    r = $bits(in_req_t)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom});
    r.item_index = next_index++;
    r.command = ($urandom_range(0, 19) == 0) ? CMD_RSVD : 2'($urandom_range(0, 2));
    if ($urandom_range(0, 4) != 0) begin
      // Shapes placed around the query so that hits and near misses both occur.
      spread = (qr > 0 && qr < 24'h100000) ? 2 * int'(qr) + 64 : $urandom_range(16, 1 << 20);
      r.vec_a_x = near(0, spread); r.vec_a_y = near(1, spread); r.vec_a_z = near(2, spread);
      r.vec_b_x = COORD_BITS'($urandom_range(0, spread));
      r.vec_b_y = COORD_BITS'($urandom_range(0, spread));
      r.vec_b_z = COORD_BITS'($urandom_range(0, spread));
      if (r.command == CMD_AABB) begin
        r.vec_b_x = r.vec_a_x + r.vec_b_x;
        r.vec_b_y = r.vec_a_y + r.vec_b_y;
        r.vec_b_z = r.vec_a_z + r.vec_b_z;
      end
      if ($urandom_range(0, 2) != 0) begin
        perm = $urandom_range(0, 2);
        r.obb_axis_0 = unit_axis(perm, 1'($urandom_range(0, 1)));
        r.obb_axis_1 = unit_axis((perm + 1) % 3, 1'($urandom_range(0, 1)));
        r.obb_axis_2 = unit_axis((perm + 2) % 3, 1'($urandom_range(0, 1)));
      end
    end
    return r;
  endfunction

  initial begin
    in_req_t r;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Directed requests around a query of radius 0x1000 at a small centre.
    set_query(24'sh001000, -24'sh002000, 24'sh000800, 23'h001000);
    r = '0; r.command = CMD_SPHERE; r.vec_a_x = qc[0]; r.vec_a_y = qc[1]; r.vec_a_z = qc[2];
    r.item_index = 16'h0001; send(r);
    r.vec_a_x = qc[0] + 24'sh002000; r.item_index = 16'h0002; send(r);
    r.vec_b_x = 24'sh001000; r.item_index = 16'h0003; send(r);
    r.vec_b_x = 24'sh800000; r.item_index = 16'h0004; send(r);
    r.vec_a_x = 24'sh7FFFFF; r.vec_a_y = 24'sh800000; r.vec_b_x = 24'sh7FFFFF;
    r.item_index = 16'hFFFF; r.last_item = 1'b1; send(r);
    r = '0; r.command = CMD_AABB;
    r.vec_a_x = 24'sh800000; r.vec_a_y = 24'sh800000; r.vec_a_z = 24'sh800000;
    r.vec_b_x = 24'sh7FFFFF; r.vec_b_y = 24'sh7FFFFF; r.vec_b_z = 24'sh7FFFFF;
    r.item_index = 16'h0010; send(r);
    r.vec_a_x = qc[0] + 24'sh001000; r.vec_b_x = qc[0] + 24'sh003000;
    r.item_index = 16'h0011; send(r);
    r.vec_a_x = qc[0] + 24'sh001001; r.item_index = 16'h0012; send(r);
    // Inverted box: min above max.
    r.vec_a_x = qc[0]; r.vec_b_x = qc[0] - 24'sh001000; r.item_index = 16'h0013; send(r);
    r = '0; r.command = CMD_OBB; r.vec_a_x = qc[0] + 24'sh003000;
    r.vec_a_y = qc[1]; r.vec_a_z = qc[2];
    r.vec_b_x = 24'sh002000; r.vec_b_y = 24'sh001000; r.vec_b_z = 24'sh001000;
    r.obb_axis_0 = unit_axis(0, 0); r.obb_axis_1 = unit_axis(1, 0);
    r.obb_axis_2 = unit_axis(2, 0); r.item_index = 16'h0020; send(r);
    r.vec_b_x = 24'sh001FFF; r.item_index = 16'h0021; send(r);
    // Negative half size.
    r.vec_b_x = -24'sh002000; r.item_index = 16'h0022; send(r);
    r.obb_axis_0 = 48'hFFFF_FFFF_FFFF; r.obb_axis_1 = 48'h8000_8000_8000;
    r.obb_axis_2 = 48'h7FFF_7FFF_7FFF; r.item_index = 16'h0023; send(r);
    r = '1; r.item_index = 16'h0030; send(r);
    r.command = CMD_OBB; r.item_index = 16'h0031; send(r);
    r = '0; r.command = CMD_RSVD; r.vec_a_x = qc[0]; r.vec_a_y = qc[1]; r.vec_a_z = qc[2];
    r.item_index = 16'h0032; r.last_item = 1'b1; send(r);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: set_query('0, '0, '0, '0);
        1: set_query(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 23'h7FFFFF);
        2: set_query(24'sh800000, 24'sh800000, 24'sh800000, 23'h7FFFFF);
        3: set_query(24'sh7FFFFF, 24'sh800000, 24'sh000000, 23'h000001);
        default: set_query(COORD_BITS'($urandom), COORD_BITS'($urandom),
                           COORD_BITS'($urandom),
                           ($urandom_range(0, 1) ? 23'($urandom_range(0, 23'h8000))
                                                 : 23'($urandom)));
      endcase
      for (int n = 0; n < 82; n++) begin
        gaps_on = !(ph == 8 && n >= 30);
        r = random_request();
        r.last_item = ($urandom_range(0, 7) == 0) || (n == 81);
        send(r);
      end
      drain();
    end

    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
sv/ssot_pkg.sv
sv/sphere_shape_overlap_test_top.sv
verif/overlap_checker.sv
verif/testbench.sv
